// ----- hw/rtl/tpsg_pkg.sv -----
// Shared types, constants and arithmetic helpers for the touch position filter.
// Used by tpsg_front, tpsg_back and the top level; no dependencies.
package tpsg_pkg;

	localparam int RAW_W   = 12;
	localparam int LEN_W   = 16;
	localparam int VAL_W   = 20;
	localparam int TAPS    = 15;
	localparam int ACC_W   = 34;
	localparam int QUO_W   = 32;
	localparam int LANES   = 4;
	localparam int AXES    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int MAG_W   = 30;
	localparam int RCP_W   = 31;
	localparam int PROD_W  = MAG_W + RCP_W;

	// floor(n / 1105) and floor(n / 280) for n below 2^30 as (n * rcp) >> shift
	localparam logic [RCP_W-1:0] SMOOTH_RCP   = 31'd1990066295;
	localparam int               SMOOTH_SHIFT = 41;
	localparam logic [RCP_W-1:0] SLOPE_RCP    = 31'd1963413622;
	localparam int               SLOPE_SHIFT  = 39;

	localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_LENGTH_Q8 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LENGTH_Q8 = 3'd5;

	typedef struct packed {
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
		logic             touched;
	} req_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_raw_max;
		logic [RAW_W-1:0] x_raw_min;
		logic [LEN_W-1:0] x_length_q8;
		logic [RAW_W-1:0] y_raw_max;
		logic [RAW_W-1:0] y_raw_min;
		logic [LEN_W-1:0] y_length_q8;
	} cfg_t;

	typedef struct packed {
		logic [RAW_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POS  = 5'b00010,
		S_MAC  = 5'b00100,
		S_QUO  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	function automatic div_lane_t div_step(div_lane_t l, logic [RAW_W-1:0] d);
		logic [RAW_W:0] t;
		logic           ge;
		div_lane_t      r;
		t = {l.rem, l.quo[QUO_W-1]};
		ge = (t >= {1'b0, d});
		r.rem = ge ? RAW_W'(t - {1'b0, d}) : t[RAW_W-1:0];
		r.quo = {l.quo[QUO_W-2:0], ge};
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_val(logic neg, logic [QUO_W-1:0] mag);
		logic signed [VAL_W-1:0] r;
		if (neg) begin
			if (mag > QUO_W'(524288)) r = -20'sd524288;
			else r = $signed(VAL_W'(0) - mag[VAL_W-1:0]);
		end else begin
			if (mag > QUO_W'(524287)) r = 20'sd524287;
			else r = $signed(mag[VAL_W-1:0]);
		end
		return r;
	endfunction

	function automatic logic signed [8:0] smooth_coef(logic [3:0] idx);
		logic signed [8:0] c;
		case (idx)
			4'd0, 4'd14: c = -9'sd78;
			4'd1, 4'd13: c = -9'sd13;
			4'd2, 4'd12: c = 9'sd42;
			4'd3, 4'd11: c = 9'sd87;
			4'd4, 4'd10: c = 9'sd122;
			4'd5, 4'd9:  c = 9'sd147;
			4'd6, 4'd8:  c = 9'sd162;
			4'd7:        c = 9'sd167;
			default:     c = 9'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [8:0] slope_coef(logic [3:0] idx);
		return $signed({5'd0, idx}) - 9'sd7;
	endfunction

endpackage

// ----- hw/rtl/tpsg_front.sv -----
// Front end: accepts raw touch requests into a two-entry queue.
// Depends on tpsg_pkg; feeds tpsg_back.
module tpsg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tpsg_pkg::req_t in_req,
	output logic          q_valid,
	input  logic          q_ready,
	output tpsg_pkg::req_t q_req
);
	import tpsg_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_stall = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_req    = slot_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- hw/rtl/tpsg_back.sv -----
// Back end: serial position division, window update, filter accumulation and
// reciprocal scaling by the filter denominators. Depends on tpsg_pkg.
module tpsg_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tpsg_pkg::cfg_t         cfg,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  tpsg_pkg::req_t         q_req,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [19:0]     smooth_x,
	output logic signed [19:0]     smooth_y,
	output logic signed [19:0]     slope_x,
	output logic signed [19:0]     slope_y
);
	import tpsg_pkg::*;

	state_t                  state_q;
	logic [4:0]              cnt_q;
	div_lane_t               lane_q [AXES];
	logic [RAW_W-1:0]        den_q  [AXES];
	logic                    neg_q  [LANES];
	logic [MAG_W-1:0]        mag_q  [LANES];
	logic                    touched_q, zero_x_q, zero_y_q;
	logic signed [VAL_W-1:0] held_x_q, held_y_q;
	logic signed [VAL_W-1:0] win_x_q [TAPS];
	logic signed [VAL_W-1:0] win_y_q [TAPS];
	logic signed [ACC_W-1:0] acc_q  [LANES];
	logic signed [VAL_W-1:0] res_q  [LANES];
	logic                    out_valid_q;

	div_lane_t               lane_nx [AXES];
	logic signed [ACC_W-1:0] acc_nx  [LANES];
	logic [ACC_W-1:0]        acc_abs [LANES];
	logic [QUO_W-1:0]        quo_nx  [LANES];
	logic signed [VAL_W-1:0] new_x, new_y;
	logic [RAW_W-1:0]        span_x, span_y;
	logic signed [RAW_W:0]   diff_x, diff_y;
	logic signed [29:0]      prod_x, prod_y;
	logic [29:0]             pabs_x, pabs_y;
	logic signed [8:0]       c_sm, c_sl;
	logic                    load_out;

	assign q_ready  = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		span_x = cfg.x_raw_max - cfg.x_raw_min;
		span_y = cfg.y_raw_max - cfg.y_raw_min;
		diff_x = $signed({1'b0, q_req.raw_x}) - $signed({2'b0, span_x[RAW_W-1:1]});
		diff_y = $signed({1'b0, q_req.raw_y}) - $signed({2'b0, span_y[RAW_W-1:1]});
		prod_x = diff_x * $signed({1'b0, cfg.x_length_q8});
		prod_y = diff_y * $signed({1'b0, cfg.y_length_q8});
		pabs_x = prod_x[29] ? 30'(-prod_x) : 30'(prod_x);
		pabs_y = prod_y[29] ? 30'(-prod_y) : 30'(prod_y);
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) lane_nx[i] = div_step(lane_q[i], den_q[i]);
		new_x = held_x_q;
		new_y = held_y_q;
		if (touched_q) begin
			new_x = zero_x_q ? '0 : sat_val(neg_q[0], lane_nx[0].quo);
			new_y = zero_y_q ? '0 : sat_val(neg_q[1], lane_nx[1].quo);
		end
		c_sm = smooth_coef(cnt_q[3:0]);
		c_sl = slope_coef(cnt_q[3:0]);
		acc_nx[0] = acc_q[0] + ACC_W'(win_x_q[0]) * ACC_W'(c_sm);
		acc_nx[1] = acc_q[1] + ACC_W'(win_y_q[0]) * ACC_W'(c_sm);
		acc_nx[2] = acc_q[2] + ACC_W'(win_x_q[0]) * ACC_W'(c_sl);
		acc_nx[3] = acc_q[3] + ACC_W'(win_y_q[0]) * ACC_W'(c_sl);
		for (int i = 0; i < LANES; i++)
			acc_abs[i] = acc_nx[i][ACC_W-1] ? ACC_W'(-acc_nx[i]) : ACC_W'(acc_nx[i]);
		quo_nx[0] = QUO_W'((PROD_W'(mag_q[0]) * PROD_W'(SMOOTH_RCP)) >> SMOOTH_SHIFT);
		quo_nx[1] = QUO_W'((PROD_W'(mag_q[1]) * PROD_W'(SMOOTH_RCP)) >> SMOOTH_SHIFT);
		quo_nx[2] = QUO_W'((PROD_W'(mag_q[2]) * PROD_W'(SLOPE_RCP)) >> SLOPE_SHIFT);
		quo_nx[3] = QUO_W'((PROD_W'(mag_q[3]) * PROD_W'(SLOPE_RCP)) >> SLOPE_SHIFT);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				touched_q <= q_req.touched;
				zero_x_q  <= (cfg.x_raw_max <= cfg.x_raw_min);
				zero_y_q  <= (cfg.y_raw_max <= cfg.y_raw_min);
				lane_q[0] <= '{rem: '0, quo: QUO_W'(pabs_x)};
				lane_q[1] <= '{rem: '0, quo: QUO_W'(pabs_y)};
				den_q[0]  <= (span_x == '0) ? RAW_W'(1) : span_x;
				den_q[1]  <= (span_y == '0) ? RAW_W'(1) : span_y;
				neg_q[0]  <= prod_x[29];
				neg_q[1]  <= prod_y[29];
			end
			S_POS: begin
				lane_q[0] <= lane_nx[0];
				lane_q[1] <= lane_nx[1];
				if (cnt_q == 5'd31) begin
					for (int i = 0; i < LANES; i++) acc_q[i] <= '0;
				end
			end
			S_MAC: begin
				for (int i = 0; i < LANES; i++) begin
					acc_q[i] <= acc_nx[i];
					mag_q[i] <= acc_abs[i][MAG_W-1:0];
					neg_q[i] <= acc_nx[i][ACC_W-1];
				end
			end
			S_QUO: begin
				for (int i = 0; i < LANES; i++) res_q[i] <= sat_val(neg_q[i], quo_nx[i]);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			smooth_x <= res_q[0];
			smooth_y <= res_q[1];
			slope_x  <= res_q[2];
			slope_y  <= res_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			for (int i = 0; i < TAPS; i++) begin
				win_x_q[i] <= '0;
				win_y_q[i] <= '0;
			end
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (q_valid) state_q <= S_POS;
				end
				S_POS: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						for (int i = 0; i < TAPS - 1; i++) begin
							win_x_q[i] <= win_x_q[i+1];
							win_y_q[i] <= win_y_q[i+1];
						end
						win_x_q[TAPS-1] <= new_x;
						win_y_q[TAPS-1] <= new_y;
						held_x_q <= new_x;
						held_y_q <= new_y;
						cnt_q    <= '0;
						state_q  <= S_MAC;
					end
				end
				S_MAC: begin
					for (int i = 0; i < TAPS - 1; i++) begin
						win_x_q[i] <= win_x_q[i+1];
						win_y_q[i] <= win_y_q[i+1];
					end
					win_x_q[TAPS-1] <= win_x_q[0];
					win_y_q[TAPS-1] <= win_y_q[0];
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd14) begin
						cnt_q   <= '0;
						state_q <= S_QUO;
					end
				end
				S_QUO: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ----- hw/rtl/touch_position_sg_filter_unit.sv -----
// Touch position Savitzky-Golay filter, top level.
// Holds the configuration registers; depends on tpsg_pkg, tpsg_front, tpsg_back.
//
// Usage:
//   Input channel: raw_x, raw_y, touched move on in_valid with in_stall low.
//   A two-entry request queue sits in front of the compute engine.
//   Output channel: smooth_x, smooth_y, slope_x, slope_y move on out_valid
//   with out_stall low; the output register holds while stalled.
//   Config channel: cfg_index selects a register, cfg_data is written when
//   cfg_valid and cfg_ready are high; cfg_ready is always high and indexes
//   past the register list are dropped. Write only while the block is idle.
//   From acceptance a request passes through the queue, the serial position
//   divider and filter accumulation, then reciprocal scaling and the output
//   load.
//   The engine takes a new request only once it is back in idle after the
//   output load of the last one; the queue holds requests meanwhile.
//   Reset: registers return to their defaults, held positions and windows
//   clear, the queue empties and out_valid drops.
//   When the receiver stalls, the engine finishes its request and waits;
//   the queue keeps accepting until it holds two requests.
module touch_position_sg_filter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        raw_x,
	input  logic [11:0]        raw_y,
	input  logic               touched,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [19:0] smooth_x,
	output logic signed [19:0] smooth_y,
	output logic signed [19:0] slope_x,
	output logic signed [19:0] slope_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import tpsg_pkg::*;

	cfg_t cfg_q;
	req_t in_req, q_req;
	logic q_valid, q_ready;

	assign cfg_ready = 1'b1;
	assign in_req = '{raw_x: raw_x, raw_y: raw_y, touched: touched};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_raw_max   <= 12'd3900;
			cfg_q.x_raw_min   <= 12'd130;
			cfg_q.x_length_q8 <= 16'd45192;
			cfg_q.y_raw_max   <= 12'd3900;
			cfg_q.y_raw_min   <= 12'd252;
			cfg_q.y_length_q8 <= 16'd34658;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_RAW_MAX:   cfg_q.x_raw_max   <= cfg_data[11:0];
				REG_X_RAW_MIN:   cfg_q.x_raw_min   <= cfg_data[11:0];
				REG_X_LENGTH_Q8: cfg_q.x_length_q8 <= cfg_data;
				REG_Y_RAW_MAX:   cfg_q.y_raw_max   <= cfg_data[11:0];
				REG_Y_RAW_MIN:   cfg_q.y_raw_min   <= cfg_data[11:0];
				REG_Y_LENGTH_Q8: cfg_q.y_length_q8 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tpsg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req)
	);

	tpsg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_req     (q_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.smooth_x  (smooth_x),
		.smooth_y  (smooth_y),
		.slope_x   (slope_x),
		.slope_y   (slope_y)
	);
endmodule
